FILE: rtl/uvc_pkg.sv
package uvc_pkg;

	localparam int FRACTION_BITS = 16;
	localparam int CORDIC_STEPS  = 16;
	localparam int EX_W          = 38;
	localparam int Z_W           = 20;
	localparam int XY_W          = 34;
	localparam int CS_W          = 18;
	localparam int PR_W          = 56;
	localparam int V_W           = 45;
	localparam int GP_W          = 58;
	localparam int FIFO_DEPTH    = 4;
	localparam int FIFO_AW       = $clog2(FIFO_DEPTH);

	localparam logic signed [Z_W-1:0]  ANG_PI      = Z_W'(205887);
	localparam logic signed [Z_W-1:0]  ANG_HALF_PI = Z_W'(102944);
	localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);

	localparam logic [2:0] REG_GRID_SHIFT  = 3'd0;
	localparam logic [2:0] REG_SCALE_RECIP = 3'd1;
	localparam logic [2:0] REG_GAIN        = 3'd2;
	localparam logic [2:0] REG_MAX_LINEAR  = 3'd3;
	localparam logic [2:0] REG_MAX_ANGULAR = 3'd4;

	typedef struct packed {
		logic [11:0] grid_shift;
		logic [23:0] grid_scale_recip;
		logic [23:0] gain;
		logic [30:0] max_linear;
		logic [30:0] max_angular;
	} uvc_cfg_t;

	typedef struct packed {
		logic [2:0]             vehicle_id;
		logic signed [EX_W-1:0] ex;
		logic signed [EX_W-1:0] ey;
		logic signed [Z_W-1:0]  z;
		logic                   neg;
	} uvc_work_t;

	// arctangent of 2^-i in Q16 radians
	function automatic logic signed [Z_W-1:0] atan_q16(input int i);
		case (i)
			0:       atan_q16 = Z_W'(51472);
			1:       atan_q16 = Z_W'(30385);
			2:       atan_q16 = Z_W'(16055);
			3:       atan_q16 = Z_W'(8150);
			4:       atan_q16 = Z_W'(4091);
			5:       atan_q16 = Z_W'(2047);
			6:       atan_q16 = Z_W'(1024);
			7:       atan_q16 = Z_W'(512);
			8:       atan_q16 = Z_W'(256);
			9:       atan_q16 = Z_W'(128);
			10:      atan_q16 = Z_W'(64);
			11:      atan_q16 = Z_W'(32);
			12:      atan_q16 = Z_W'(16);
			13:      atan_q16 = Z_W'(8);
			14:      atan_q16 = Z_W'(4);
			15:      atan_q16 = Z_W'(2);
			default: atan_q16 = '0;
		endcase
	endfunction

endpackage

FILE: rtl/uvc_in_if.sv
interface uvc_in_if;
	logic               valid;
	logic               ready;
	logic [2:0]         vehicle_id;
	logic [11:0]        target_x;
	logic [11:0]        target_y;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [15:0] heading;

	modport source (output valid, vehicle_id, target_x, target_y, pos_x, pos_y, heading,
		input ready);
	modport sink (input valid, vehicle_id, target_x, target_y, pos_x, pos_y, heading,
		output ready);
endinterface

FILE: rtl/uvc_out_if.sv
interface uvc_out_if;
	logic               valid;
	logic               ready;
	logic [2:0]         vehicle_id_out;
	logic signed [31:0] linear_velocity;
	logic signed [31:0] angular_velocity;

	modport source (output valid, vehicle_id_out, linear_velocity, angular_velocity,
		input ready);
	modport sink (input valid, vehicle_id_out, linear_velocity, angular_velocity,
		output ready);
endinterface

FILE: rtl/uvc_cfg_if.sv
interface uvc_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/uvc_front.sv
module uvc_front import uvc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	uvc_in_if.sink    in_ch,
	input  uvc_cfg_t  cfg,
	output uvc_work_t push_data,
	output logic      push,
	input  logic      full
);

	logic                   en;
	logic                   vld_s1, vld_s2;
	logic [2:0]             id_s1;
	logic signed [12:0]     tx_s1, ty_s1;
	logic signed [31:0]     px_s1, py_s1;
	logic signed [Z_W-1:0]  z_s1;
	logic                   neg_s1;
	uvc_work_t              work_s2;

	logic signed [Z_W-1:0]  hd8;
	logic signed [Z_W-1:0]  z_fold;
	logic                   neg_fold;
	logic signed [EX_W-1:0] prod_x, prod_y;

	assign en          = !vld_s2 || !full;
	assign in_ch.ready = en;
	assign push        = vld_s2 && !full;
	assign push_data   = work_s2;

	// fold heading by pi into the CORDIC range
	always_comb begin
		hd8      = {{(Z_W-19){in_ch.heading[15]}}, in_ch.heading, 3'b000};
		z_fold   = hd8;
		neg_fold = 1'b0;
		if (hd8 > ANG_HALF_PI) begin
			z_fold   = hd8 - ANG_PI;
			neg_fold = 1'b1;
		end else if (hd8 < -ANG_HALF_PI) begin
			z_fold   = hd8 + ANG_PI;
			neg_fold = 1'b1;
		end
	end

	// scale waypoint to world units
	assign prod_x = tx_s1 * $signed({1'b0, cfg.grid_scale_recip});
	assign prod_y = ty_s1 * $signed({1'b0, cfg.grid_scale_recip});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_ch.valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			id_s1              <= in_ch.vehicle_id;
			tx_s1              <= $signed({1'b0, in_ch.target_x}) - $signed({1'b0, cfg.grid_shift});
			ty_s1              <= $signed({1'b0, in_ch.target_y}) - $signed({1'b0, cfg.grid_shift});
			px_s1              <= in_ch.pos_x;
			py_s1              <= in_ch.pos_y;
			z_s1               <= z_fold;
			neg_s1             <= neg_fold;
			work_s2.vehicle_id <= id_s1;
			work_s2.ex         <= prod_x - EX_W'(px_s1);
			work_s2.ey         <= prod_y - EX_W'(py_s1);
			work_s2.z          <= z_s1;
			work_s2.neg        <= neg_s1;
		end
	end

endmodule

FILE: rtl/uvc_fifo.sv
module uvc_fifo import uvc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  uvc_work_t push_data,
	output logic      full,
	input  logic      pop,
	output uvc_work_t pop_data,
	output logic      empty
);

	uvc_work_t          mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW:0]   count_q;

	assign full     = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem[rd_ptr_q];

	// advance pointers and track fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= push_data;
	end

endmodule

FILE: rtl/uvc_back.sv
module uvc_back import uvc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  uvc_work_t pop_data,
	input  logic      empty,
	output logic      pop,
	input  uvc_cfg_t  cfg,
	uvc_out_if.source out_ch
);

	localparam int LAST = CORDIC_STEPS;

	logic en;

	// CORDIC stages
	logic                   cv_s [0:LAST];
	logic signed [XY_W-1:0] cx_s [0:LAST];
	logic signed [XY_W-1:0] cy_s [0:LAST];
	logic signed [Z_W-1:0]  cz_s [0:LAST];
	uvc_work_t              cw_s [0:LAST];

	// later stages
	logic                   vld_s17, vld_s18, vld_s19, vld_s20, vld_s21;
	logic [2:0]             id_s17, id_s18, id_s19, id_s20, id_s21;
	logic signed [EX_W-1:0] ex_s17, ey_s17;
	logic signed [CS_W-1:0] c_s17, s_s17;
	logic signed [PR_W-1:0] xc_s18, ys_s18, yc_s18, xs_s18;
	logic signed [V_W-1:0]  lin_s19, ang_s19;
	logic signed [GP_W-1:0] lh_s20, ll_s20, ah_s20, al_s20;
	logic                   lhi_s21, llo_s21, ahi_s21, alo_s21;
	logic signed [53:0]     lr_s21, ar_s21;

	logic                   vld_q;
	logic [2:0]             id_q;
	logic signed [31:0]     lin_q, ang_q;

	logic signed [CS_W-1:0] c_rnd, s_rnd;
	logic signed [PR_W:0]   lin_sum, ang_sum;
	logic signed [V_W-1:0]  lin_v, ang_r, ang_v;
	logic signed [69:0]     lin_full, ang_full;
	logic signed [31:0]     lin_sat, ang_sat, lin_clamp, ang_clamp;

	localparam logic signed [GP_W-1:0] G_LIM = GP_W'(64'sd1 << 50);

	assign en  = !vld_q || out_ch.ready;
	assign pop = en && !empty;

	// load stage zero from the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cv_s[0] <= 1'b0;
		else if (en)
			cv_s[0] <= !empty;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s[0] <= CORDIC_GAIN;
			cy_s[0] <= '0;
			cz_s[0] <= pop_data.z;
			cw_s[0] <= pop_data;
		end
	end

	// one micro-rotation per stage
	for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_rot
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				cv_s[g+1] <= 1'b0;
			else if (en)
				cv_s[g+1] <= cv_s[g];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				cw_s[g+1] <= cw_s[g];
				if (!cz_s[g][Z_W-1]) begin
					cx_s[g+1] <= cx_s[g] - (cy_s[g] >>> g);
					cy_s[g+1] <= cy_s[g] + (cx_s[g] >>> g);
					cz_s[g+1] <= cz_s[g] - atan_q16(g);
				end else begin
					cx_s[g+1] <= cx_s[g] + (cy_s[g] >>> g);
					cy_s[g+1] <= cy_s[g] - (cx_s[g] >>> g);
					cz_s[g+1] <= cz_s[g] + atan_q16(g);
				end
			end
		end
	end

	// round CORDIC outputs to Q16
	assign c_rnd = CS_W'((cx_s[LAST] + XY_W'(8192)) >>> 14);
	assign s_rnd = CS_W'((cy_s[LAST] + XY_W'(8192)) >>> 14);

	// rotate errors, round, scale angular by ten
	assign lin_sum = (PR_W+1)'(xc_s18) + (PR_W+1)'(ys_s18) + (PR_W+1)'(1 << 15);
	assign ang_sum = (PR_W+1)'(yc_s18) - (PR_W+1)'(xs_s18) + (PR_W+1)'(1 << 15);
	assign lin_v   = V_W'(lin_sum >>> 16);
	assign ang_r   = V_W'(ang_sum >>> 16);
	assign ang_v   = (ang_r <<< 3) + (ang_r <<< 1);

	// combine gain partial products with rounding
	assign lin_full = ({{12{lh_s20[GP_W-1]}}, lh_s20} <<< 12) + 70'(ll_s20)
		+ 70'(1 << (FRACTION_BITS-1));
	assign ang_full = ({{12{ah_s20[GP_W-1]}}, ah_s20} <<< 12) + 70'(al_s20)
		+ 70'(1 << (FRACTION_BITS-1));

	// saturate to 32 bits, then clamp from above
	always_comb begin
		if (lhi_s21 || lr_s21 > 54'sh7FFFFFFF)
			lin_sat = 32'sh7FFFFFFF;
		else if (llo_s21 || lr_s21 < -54'sh80000000)
			lin_sat = 32'sh80000000;
		else
			lin_sat = lr_s21[31:0];
		if (ahi_s21 || ar_s21 > 54'sh7FFFFFFF)
			ang_sat = 32'sh7FFFFFFF;
		else if (alo_s21 || ar_s21 < -54'sh80000000)
			ang_sat = 32'sh80000000;
		else
			ang_sat = ar_s21[31:0];
		lin_clamp = lin_sat;
		ang_clamp = ang_sat;
		if (lin_sat > $signed({1'b0, cfg.max_linear}))
			lin_clamp = $signed({1'b0, cfg.max_linear});
		if (ang_sat > $signed({1'b0, cfg.max_angular}))
			ang_clamp = $signed({1'b0, cfg.max_angular});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s17 <= 1'b0;
			vld_s18 <= 1'b0;
			vld_s19 <= 1'b0;
			vld_s20 <= 1'b0;
			vld_s21 <= 1'b0;
			vld_q   <= 1'b0;
		end else if (en) begin
			vld_s17 <= cv_s[LAST];
			vld_s18 <= vld_s17;
			vld_s19 <= vld_s18;
			vld_s20 <= vld_s19;
			vld_s21 <= vld_s20;
			vld_q   <= vld_s21;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			id_s17  <= cw_s[LAST].vehicle_id;
			ex_s17  <= cw_s[LAST].ex;
			ey_s17  <= cw_s[LAST].ey;
			c_s17   <= cw_s[LAST].neg ? CS_W'(-c_rnd) : CS_W'(c_rnd);
			s_s17   <= cw_s[LAST].neg ? CS_W'(-s_rnd) : CS_W'(s_rnd);

			id_s18  <= id_s17;
			xc_s18  <= ex_s17 * c_s17;
			ys_s18  <= ey_s17 * s_s17;
			yc_s18  <= ey_s17 * c_s17;
			xs_s18  <= ex_s17 * s_s17;

			id_s19  <= id_s18;
			lin_s19 <= lin_v;
			ang_s19 <= ang_v;

			id_s20  <= id_s19;
			lh_s20  <= lin_s19 * $signed({1'b0, cfg.gain[23:12]});
			ll_s20  <= lin_s19 * $signed({1'b0, cfg.gain[11:0]});
			ah_s20  <= ang_s19 * $signed({1'b0, cfg.gain[23:12]});
			al_s20  <= ang_s19 * $signed({1'b0, cfg.gain[11:0]});

			id_s21  <= id_s20;
			lhi_s21 <= lh_s20 >= G_LIM;
			llo_s21 <= lh_s20 <= -G_LIM;
			ahi_s21 <= ah_s20 >= G_LIM;
			alo_s21 <= ah_s20 <= -G_LIM;
			lr_s21  <= 54'(lin_full >>> FRACTION_BITS);
			ar_s21  <= 54'(ang_full >>> FRACTION_BITS);

			id_q    <= id_s21;
			lin_q   <= lin_clamp;
			ang_q   <= ang_clamp;
		end
	end

	assign out_ch.valid            = vld_q;
	assign out_ch.vehicle_id_out   = id_q;
	assign out_ch.linear_velocity  = lin_q;
	assign out_ch.angular_velocity = ang_q;

endmodule

FILE: rtl/unicycle_velocity_controller_core.sv
// Unicycle velocity controller. Takes a grid waypoint, the measured Q16.16 position and a
// Q2.13 heading, and returns linear and angular velocity in Q16.16. A two-stage front end
// scales the waypoint and forms the errors, then a four-entry queue feeds a back end of a
// 16-stage pipelined CORDIC followed by rotation, gain and clamp stages. Sustained rate
// is one item per clock while out_ch is ready. Registers are written through the cfg
// channel; the user must write them only while idle, as the block does not enforce it.
module unicycle_velocity_controller_core import uvc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	uvc_in_if.sink     in_ch,
	uvc_out_if.source  out_ch,
	uvc_cfg_if.sink    cfg
);

	uvc_cfg_t  cfg_q;
	uvc_work_t push_data, pop_data;
	logic      push, pop, full, empty;

	assign cfg.ready = 1'b1;

	// register writes; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_shift       <= '0;
			cfg_q.grid_scale_recip <= 24'd65536;
			cfg_q.gain             <= 24'd65536;
			cfg_q.max_linear       <= 31'd32768;
			cfg_q.max_angular      <= 31'd65536;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_GRID_SHIFT:  cfg_q.grid_shift       <= cfg.data[11:0];
				REG_SCALE_RECIP: cfg_q.grid_scale_recip <= cfg.data[23:0];
				REG_GAIN:        cfg_q.gain             <= cfg.data[23:0];
				REG_MAX_LINEAR:  cfg_q.max_linear       <= cfg.data[30:0];
				REG_MAX_ANGULAR: cfg_q.max_angular      <= cfg.data[30:0];
				default: ;
			endcase
		end
	end

	uvc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.cfg       (cfg_q),
		.push_data (push_data),
		.push      (push),
		.full      (full)
	);

	uvc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	uvc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_data (pop_data),
		.empty    (empty),
		.pop      (pop),
		.cfg      (cfg_q),
		.out_ch   (out_ch)
	);

endmodule

FILE: dv/tb_unicycle_velocity_controller_core.sv
module tb_unicycle_velocity_controller_core;
	import uvc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int  CYCLE_LIMIT = 600000;
	localparam int  DRAIN_CYCLES = 40;
	localparam logic [2:0] REG_UNUSED = 3'd5;
	localparam longint CORDIC_X0 = 652032874;
	localparam longint PI_Q16 = 205887;
	localparam longint HALF_PI_Q16 = 102944;
	localparam longint ARCTAN_Q16 [16] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
		256, 128, 64, 32, 16, 8, 4, 2};

	typedef struct packed {
		logic [2:0]         vehicle_id;
		logic signed [31:0] linear;
		logic signed [31:0] angular;
	} velocity_cmd_t;

	logic clk;
	logic arst_n;
	int   cycles;
	int   errors;
	bit   calm;

	uvc_in_if  in_ch();
	uvc_out_if out_ch();
	uvc_cfg_if cfg();

	// shadow register file
	logic [11:0] shift_q;
	logic [23:0] recip_q;
	logic [23:0] gain_q;
	logic [30:0] max_lin_q;
	logic [30:0] max_ang_q;

	velocity_cmd_t pending_cmds[$];

	unicycle_velocity_controller_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// sine and cosine of a Q16 angle, both Q16
	function automatic void heading_trig(input longint ang, output longint s, output longint c);
		longint x, y, z, nx;
		bit     flip;
		x = CORDIC_X0;
		y = 0;
		z = ang;
		flip = 1'b0;
		if (z > HALF_PI_Q16) begin
			z -= PI_Q16;
			flip = 1'b1;
		end else if (z < -HALF_PI_Q16) begin
			z += PI_Q16;
			flip = 1'b1;
		end
		for (int i = 0; i < 16; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y  = y + (x >>> i);
				z -= ARCTAN_Q16[i];
			end else begin
				nx = x + (y >>> i);
				y  = y - (x >>> i);
				z += ARCTAN_Q16[i];
			end
			x = nx;
		end
		c = (x + (64'sd1 <<< 13)) >>> 14;
		s = (y + (64'sd1 <<< 13)) >>> 14;
		if (flip) begin
			c = -c;
			s = -s;
		end
	endfunction

	function automatic longint clip32(input longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	// multiply by Q8.16 gain, split to keep the product inside 64 bits
	function automatic longint scale_by_gain(input longint v);
		longint hi, lo;
		hi = v * longint'(gain_q[23:12]);
		lo = v * longint'(gain_q[11:0]);
		if (hi >= (64'sd1 <<< 50))
			return 64'sd2147483647;
		if (hi <= -(64'sd1 <<< 50))
			return -64'sd2147483648;
		return clip32((hi * 4096 + lo + (64'sd1 <<< 15)) >>> 16);
	endfunction

	function automatic velocity_cmd_t steer_command(input logic [2:0] id,
		input logic [11:0] tgt_x, input logic [11:0] tgt_y,
		input logic signed [31:0] px, input logic signed [31:0] py,
		input logic signed [15:0] hdg);
		velocity_cmd_t cmd;
		longint ex, ey, s, c, lin, ang;
		ex = (longint'(tgt_x) - longint'(shift_q)) * longint'(recip_q) - longint'(px);
		ey = (longint'(tgt_y) - longint'(shift_q)) * longint'(recip_q) - longint'(py);
		heading_trig(longint'(hdg) * 8, s, c);
		lin = (ex * c + ey * s + (64'sd1 <<< 15)) >>> 16;
		ang = ((ey * c - ex * s + (64'sd1 <<< 15)) >>> 16) * 10;
		lin = scale_by_gain(lin);
		ang = scale_by_gain(ang);
		if (lin > longint'(max_lin_q))
			lin = longint'(max_lin_q);
		if (ang > longint'(max_ang_q))
			ang = longint'(max_ang_q);
		cmd.vehicle_id = id;
		cmd.linear     = lin[31:0];
		cmd.angular    = ang[31:0];
		return cmd;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// send one item and record its expected command
	task automatic send_item(input logic [2:0] id, input logic [11:0] tgt_x,
		input logic [11:0] tgt_y, input logic signed [31:0] px, input logic signed [31:0] py,
		input logic signed [15:0] hdg);
		int gap;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			in_ch.valid <= 1'b0;
		end
		@(negedge clk);
		in_ch.valid      <= 1'b1;
		in_ch.vehicle_id <= id;
		in_ch.target_x   <= tgt_x;
		in_ch.target_y   <= tgt_y;
		in_ch.pos_x      <= px;
		in_ch.pos_y      <= py;
		in_ch.heading    <= hdg;
		do
			@(posedge clk);
		while (!in_ch.ready);
		pending_cmds.insert(pending_cmds.size(), steer_command(id, tgt_x, tgt_y, px, py, hdg));
	endtask

	// hold off until every command is back, then let the pipe settle
	task automatic wait_idle();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (pending_cmds.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		do
			@(posedge clk);
		while (!cfg.ready);
		case (idx)
			REG_GRID_SHIFT:  shift_q   = value[11:0];
			REG_SCALE_RECIP: recip_q   = value[23:0];
			REG_GAIN:        gain_q    = value[23:0];
			REG_MAX_LINEAR:  max_lin_q = value[30:0];
			REG_MAX_ANGULAR: max_ang_q = value[30:0];
			default: ;
		endcase
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic write_all(input logic [11:0] sh, input logic [23:0] rc, input logic [23:0] g,
		input logic [30:0] ml, input logic [30:0] ma);
		write_reg(REG_GRID_SHIFT, {$urandom} & 32'hFFFF_F000 | 32'(sh));
		write_reg(REG_SCALE_RECIP, 32'(rc));
		write_reg(REG_GAIN, 32'(g));
		write_reg(REG_MAX_LINEAR, {1'($urandom), 31'h0} | 32'(ml));
		write_reg(REG_MAX_ANGULAR, 32'(ma));
	endtask

	// random item, mostly with the robot close to its waypoint
	task automatic send_random();
		logic [11:0]        tx, ty;
		logic signed [31:0] px, py;
		longint             wx, wy;
		tx = 12'($urandom);
		ty = 12'($urandom);
		if ($urandom_range(0, 3) == 0) begin
			px = $urandom;
			py = $urandom;
		end else begin
			wx = (longint'(tx) - longint'(shift_q)) * longint'(recip_q);
			wy = (longint'(ty) - longint'(shift_q)) * longint'(recip_q);
			px = 32'(wx + longint'($signed(20'($urandom))));
			py = 32'(wy + longint'($signed(20'($urandom))));
		end
		send_item(3'($urandom), tx, ty, px, py, 16'($urandom));
	endtask

	task automatic test_field_extremes();
		calm = 1'b1;
		write_all(12'd2048, 24'd65536, 24'd65536, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
		write_reg(REG_UNUSED, 32'hFFFF_FFFF);
		send_item(3'd0, 12'd0, 12'd0, 32'sd0, 32'sd0, 16'sd0);
		send_item(3'd7, 12'd4095, 12'd4095, -32'sd2147483648, -32'sd2147483648, 16'sd25736);
		send_item(3'd3, 12'd0, 12'd4095, 32'sd2147483647, -32'sd2147483648, -16'sd25736);
		send_item(3'd5, 12'd2100, 12'd2000, 32'sd65536, -32'sd65536, 16'sd32767);
		send_item(3'd1, 12'd2048, 12'd2049, 32'sd0, 32'sd0, -16'sd32768);
		send_item(3'd2, 12'd2049, 12'd2048, 32'sd0, 32'sd0, 16'sd12868);
		send_item(3'd6, 12'd2049, 12'd2048, 32'sd0, 32'sd0, -16'sd12868);
		send_item(3'd4, 12'd1000, 12'd3000, 32'sd12345, -32'sd98765, 16'sd25737);
		send_item(3'd3, 12'd2048, 12'd2048, 32'sh5555_5555, 32'shAAAA_AAAA, 16'sh5555);
		send_item(3'd4, 12'hAAA, 12'h555, 32'shAAAA_AAAA, 32'sh5555_5555, 16'shAAAA);
		wait_idle();
		// huge products against zero maxima: positive velocities clamp, negative ones pass
		write_all(12'd4095, 24'hFF_FFFF, 24'hFF_FFFF, 31'd0, 31'd0);
		send_item(3'd0, 12'd0, 12'd4095, -32'sd2147483648, 32'sd2147483647, 16'sd0);
		send_item(3'd7, 12'd0, 12'd0, 32'sd2147483647, 32'sd2147483647, 16'sd25736);
		send_item(3'd2, 12'd4095, 12'd4095, -32'sd2147483648, -32'sd2147483648, 16'sd6434);
		send_item(3'd1, 12'd4095, 12'd0, 32'sd0, 32'sd0, -16'sd6434);
		wait_idle();
		write_all(12'd0, 24'd0, 24'd0, 31'd32768, 31'd65536);
		send_item(3'd5, 12'd4095, 12'd4095, 32'sd2147483647, -32'sd2147483648, 16'sd100);
		send_item(3'd6, 12'd17, 12'd99, 32'sd100, 32'sd200, -16'sd100);
		wait_idle();
		calm = 1'b0;
	endtask

	task automatic test_random_settings();
		for (int phase = 0; phase < 7; phase++) begin
			case (phase)
				0: write_all(12'd0, 24'd65536, 24'd65536, 31'd32768, 31'd65536);
				1: write_all(12'd4095, 24'hFF_FFFF, 24'hFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
				2: write_all(12'd0, 24'd1, 24'd1, 31'd0, 31'd0);
				default: write_all(12'($urandom), 24'($urandom_range(0, 24'h04_0000)),
					24'($urandom_range(0, 24'h04_0000)), 31'($urandom),
					31'($urandom_range(0, 32'h0010_0000)));
			endcase
			calm = (phase == 3);
			repeat (150) send_random();
			wait_idle();
		end
		calm = 1'b0;
	endtask

	// result sink back-pressure: mostly ready, short stalls and a few long ones
	int stall_left;
	always @(negedge clk) begin
		int r;
		r = $urandom_range(0, 99);
		if (!arst_n || calm) begin
			out_ch.ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ch.ready <= 1'b0;
		end else begin
			if (r < 3)
				stall_left <= $urandom_range(8, 40);
			out_ch.ready <= (r >= 25);
		end
	end

	// compare each returned command with the oldest prediction
	always @(posedge clk) begin
		velocity_cmd_t exp_cmd;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_cmds.size() == 0) begin
				$display("%0t: unexpected command id=%0d lin=%0d ang=%0d", $realtime,
					out_ch.vehicle_id_out, out_ch.linear_velocity, out_ch.angular_velocity);
				errors++;
			end else begin
				exp_cmd = pending_cmds.pop_front();
				if (out_ch.vehicle_id_out !== exp_cmd.vehicle_id) begin
					$display("%0t: vehicle_id expected %0d actual %0d", $realtime,
						exp_cmd.vehicle_id, out_ch.vehicle_id_out);
					errors++;
				end
				if (out_ch.linear_velocity !== exp_cmd.linear) begin
					$display("%0t: linear_velocity expected %0d actual %0d", $realtime,
						exp_cmd.linear, out_ch.linear_velocity);
					errors++;
				end
				if (out_ch.angular_velocity !== exp_cmd.angular) begin
					$display("%0t: angular_velocity expected %0d actual %0d", $realtime,
						exp_cmd.angular, out_ch.angular_velocity);
					errors++;
				end
			end
		end
	end

	initial begin
		calm = 1'b0;
		shift_q = 12'd0;
		recip_q = 24'd65536;
		gain_q = 24'd65536;
		max_lin_q = 31'd32768;
		max_ang_q = 31'd65536;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.vehicle_id = '0;
		in_ch.target_x = '0;
		in_ch.target_y = '0;
		in_ch.pos_x = '0;
		in_ch.pos_y = '0;
		in_ch.heading = '0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_field_extremes();
		test_random_settings();
		wait_idle();

		if (errors == 0 && pending_cmds.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/uvc_pkg.sv
rtl/uvc_in_if.sv
rtl/uvc_out_if.sv
rtl/uvc_cfg_if.sv
rtl/uvc_front.sv
rtl/uvc_fifo.sv
rtl/uvc_back.sv
rtl/unicycle_velocity_controller_core.sv
dv/tb_unicycle_velocity_controller_core.sv
